// ===== rtl/core/psp_pkg.sv =====
// Shared constants, types and the slot-index helper function of the particle slot pool.
`default_nettype none
package psp_pkg;
    localparam int SLOTS     = 2048;
    localparam int SLOT_W    = 11;
    localparam int CNT_W     = 12;
    localparam int AW        = $clog2(SLOTS);
    localparam int RETRY_MAX = SLOTS / 3;
    localparam int RETRY_W   = $clog2(RETRY_MAX + 1);

    typedef logic [AW-1:0] t_addr;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_PKIND  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_C_RD,
        S_C_CHK,
        S_C_WR,
        S_T_RD,
        S_T_CHK,
        S_T_MUL,
        S_T_WR,
        S_RES
    } t_state;

    typedef struct packed {
        logic             live;
        logic [3:0]       kind;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [31:0]      age;
        logic [31:0]      life;
        logic [31:0]      tag;
    } t_rec;

    typedef struct packed {
        logic  en;
        t_addr addr;
        t_rec  data;
    } t_wr;

    function automatic t_addr next_slot(input t_addr i);
        return (i == t_addr'(SLOTS - 1)) ? '0 : i + t_addr'(1);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/particle_slot_pool.sv =====
// Top level of the particle slot pool: sequencer, counters and result register.
// Create: read, check and write states, with one more read and check per persistent slot skipped.
// Tick: every slot is read and checked; a live slot also passes the shared multiplier
// (one axis per cycle) and is written back through the write port of the slot memory.
// Clear: one write per slot, over all slots. One request is worked on at a time.
// After reset a clearing pass over all 2048 slots runs before the first request is taken.
`default_nettype none
module particle_slot_pool (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_idx,
    input  wire  [3:0]                   i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [1:0]                   i_mode,
    input  wire  [3:0]                   i_kind,
    input  wire  signed [31:0]           i_pos_x,
    input  wire  signed [31:0]           i_pos_y,
    input  wire  signed [31:0]           i_pos_z,
    input  wire  signed [31:0]           i_vel_x,
    input  wire  signed [31:0]           i_vel_y,
    input  wire  signed [31:0]           i_vel_z,
    input  wire  [31:0]                  i_lifetime,
    input  wire  [31:0]                  i_frame_time,
    input  wire  [31:0]                  i_tag,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [psp_pkg::SLOT_W-1:0]   o_slot,
    output logic                         o_created,
    output logic                         o_evicted,
    output logic                         o_evicted_persistent,
    output logic [psp_pkg::CNT_W-1:0]    o_live_count,
    output logic [psp_pkg::CNT_W-1:0]    o_high_water
);
    import psp_pkg::*;

    // Configuration registers.
    logic       r_enable;
    logic [3:0] r_pkind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_pkind  <= 4'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_PKIND:  r_pkind  <= i_cfg_data;
                default:    r_enable <= r_enable;
            endcase
        end
    end

    // Control state.
    t_state              r_state, n_state;
    t_addr               r_idx, n_idx;
    t_addr               r_probe, n_probe;
    t_addr               r_first, n_first;
    t_addr               r_ring, n_ring;
    logic [RETRY_W-1:0]  r_retry, n_retry;
    logic [1:0]          r_k, n_k;
    logic [CNT_W-1:0]    r_live, n_live;
    logic [CNT_W-1:0]    r_peak, n_peak;
    logic                r_clr_res, n_clr_res;
    logic                r_created, n_created;
    logic                r_ev, n_ev;
    logic                r_evp, n_evp;
    logic                r_out_valid, n_out_valid;

    // Request payload, captured when a request is taken.
    logic [3:0]          r_kind;
    logic [2:0][31:0]    r_pos;
    logic [2:0][31:0]    r_vel;
    logic [31:0]         r_life;
    logic [31:0]         r_tag;
    logic [31:0]         r_ft;
    logic [2:0][31:0]    r_d;
    logic [2:0][31:0]    n_d;

    // Result register.
    logic [SLOT_W-1:0]   r_o_slot, n_o_slot;
    logic                r_o_created, n_o_created;
    logic                r_o_ev, n_o_ev;
    logic                r_o_evp, n_o_evp;
    logic [CNT_W-1:0]    r_o_live, n_o_live;
    logic [CNT_W-1:0]    r_o_peak, n_o_peak;

    t_wr   wr;
    t_addr rd_addr;
    t_rec  q;

    psp_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (q)
    );

    logic                 take;
    logic                 last_idx;
    logic [RETRY_W-1:0]   retry_inc;
    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [65:0]   mul_p;
    logic [32:0]          age_sum;
    logic [31:0]          age_new;
    logic                 expire;
    logic [CNT_W-1:0]     live_up;

    assign take      = i_in_valid && !o_in_stall;
    assign last_idx  = (r_idx == t_addr'(SLOTS - 1));
    assign retry_inc = r_retry + RETRY_W'(1);

    // One shared multiplier; the axis is chosen by r_k. Velocity is signed,
    // frame time unsigned, and the delta is the product shifted down by 16.
    assign mul_a = {q.vel[r_k][31], q.vel[r_k]};
    assign mul_b = {1'b0, r_ft};
    assign mul_p = mul_a * mul_b;

    // Saturating age update and expiry test of the slot under the tick.
    assign age_sum = {1'b0, q.age} + {1'b0, r_ft};
    assign age_new = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    assign expire  = age_new > q.life;
    assign live_up = r_live + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_probe     = r_probe;
        n_first     = r_first;
        n_ring      = r_ring;
        n_retry     = r_retry;
        n_k         = r_k;
        n_live      = r_live;
        n_peak      = r_peak;
        n_clr_res   = r_clr_res;
        n_created   = r_created;
        n_ev        = r_ev;
        n_evp       = r_evp;
        n_d         = r_d;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_slot    = r_o_slot;
        n_o_created = r_o_created;
        n_o_ev      = r_o_ev;
        n_o_evp     = r_o_evp;
        n_o_live    = r_o_live;
        n_o_peak    = r_o_peak;
        rd_addr     = r_idx;
        wr.en       = 1'b0;
        wr.addr     = r_idx;
        wr.data     = q;
        o_in_stall  = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_created = 1'b0;
                    n_ev      = 1'b0;
                    n_evp     = 1'b0;
                    n_idx     = '0;
                    n_k       = '0;
                    n_state   = S_RES;
                    case (t_mode'(i_mode))
                        MODE_CLEAR: begin
                            // Counters drop at once; the memory sweep follows.
                            n_live    = '0;
                            n_peak    = '0;
                            n_ring    = '0;
                            n_clr_res = 1'b1;
                            n_state   = S_CLR;
                        end
                        MODE_CREATE: begin
                            if (r_enable) begin
                                n_probe = r_ring;
                                n_first = r_ring;
                                n_retry = '0;
                                n_state = S_C_RD;
                            end
                        end
                        MODE_TICK: begin
                            if (r_enable) begin
                                n_state = S_T_RD;
                            end
                        end
                        default: n_state = S_RES;
                    endcase
                end
            end

            S_CLR: begin
                wr.en   = 1'b1;
                wr.addr = r_idx;
                wr.data = '0;
                n_idx   = next_slot(r_idx);
                if (last_idx) begin
                    n_state = r_clr_res ? S_RES : S_IDLE;
                end
            end

            S_C_RD: begin
                rd_addr = r_probe;
                n_state = S_C_CHK;
            end

            S_C_CHK: begin
                // The probed slot's record is on the read port now.
                if (!q.live) begin
                    n_state = S_C_WR;
                end else if (q.kind != r_pkind) begin
                    n_ev    = 1'b1;
                    n_state = S_C_WR;
                end else if (retry_inc < RETRY_W'(RETRY_MAX)) begin
                    n_retry = retry_inc;
                    n_probe = next_slot(r_probe);
                    n_state = S_C_RD;
                end else begin
                    // Every probe hit a persistent occupant: overwrite the first one.
                    n_probe = r_first;
                    n_ev    = 1'b1;
                    n_evp   = 1'b1;
                    n_state = S_C_WR;
                end
            end

            S_C_WR: begin
                wr.en           = 1'b1;
                wr.addr         = r_probe;
                wr.data.live    = 1'b1;
                wr.data.kind    = r_kind;
                wr.data.pos     = r_pos;
                wr.data.vel     = r_vel;
                wr.data.age     = '0;
                wr.data.life    = r_life;
                wr.data.tag     = r_tag;
                n_ring          = next_slot(r_probe);
                n_created       = 1'b1;
                // An eviction frees one slot and fills it again: no net change.
                if (!r_ev) begin
                    n_live = live_up;
                    if (live_up > r_peak) begin
                        n_peak = live_up;
                    end
                end
                n_state = S_RES;
            end

            S_T_RD: begin
                rd_addr = r_idx;
                n_state = S_T_CHK;
            end

            S_T_CHK: begin
                rd_addr = r_idx;
                if (q.live) begin
                    n_k     = '0;
                    n_state = S_T_MUL;
                end else begin
                    n_idx   = next_slot(r_idx);
                    n_state = last_idx ? S_RES : S_T_RD;
                end
            end

            S_T_MUL: begin
                rd_addr      = r_idx;
                n_d[r_k]     = mul_p[47:16];
                n_k          = r_k + 2'd1;
                if (r_k == 2'd2) begin
                    n_state = S_T_WR;
                end
            end

            S_T_WR: begin
                rd_addr         = r_idx;
                wr.en           = 1'b1;
                wr.addr         = r_idx;
                wr.data         = q;
                wr.data.pos[0]  = q.pos[0] + r_d[0];
                wr.data.pos[1]  = q.pos[1] + r_d[1];
                wr.data.pos[2]  = q.pos[2] + r_d[2];
                wr.data.age     = age_new;
                wr.data.live    = !expire;
                if (expire) begin
                    n_live = r_live - CNT_W'(1);
                end
                n_idx   = next_slot(r_idx);
                n_state = last_idx ? S_RES : S_T_RD;
            end

            S_RES: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_slot    = r_created ? SLOT_W'(r_probe) : '0;
                    n_o_created = r_created;
                    n_o_ev      = r_ev;
                    n_o_evp     = r_evp;
                    n_o_live    = r_live;
                    n_o_peak    = r_peak;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Reset starts a silent clearing pass over the whole memory.
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_probe     <= '0;
            r_first     <= '0;
            r_ring      <= '0;
            r_retry     <= '0;
            r_k         <= '0;
            r_live      <= '0;
            r_peak      <= '0;
            r_clr_res   <= 1'b0;
            r_created   <= 1'b0;
            r_ev        <= 1'b0;
            r_evp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_probe     <= n_probe;
            r_first     <= n_first;
            r_ring      <= n_ring;
            r_retry     <= n_retry;
            r_k         <= n_k;
            r_live      <= n_live;
            r_peak      <= n_peak;
            r_clr_res   <= n_clr_res;
            r_created   <= n_created;
            r_ev        <= n_ev;
            r_evp       <= n_evp;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= i_kind;
            r_pos  <= {i_pos_z, i_pos_y, i_pos_x};
            r_vel  <= {i_vel_z, i_vel_y, i_vel_x};
            r_life <= i_lifetime;
            r_tag  <= i_tag;
            r_ft   <= i_frame_time;
        end
        r_d         <= n_d;
        r_o_slot    <= n_o_slot;
        r_o_created <= n_o_created;
        r_o_ev      <= n_o_ev;
        r_o_evp     <= n_o_evp;
        r_o_live    <= n_o_live;
        r_o_peak    <= n_o_peak;
    end

    assign o_out_valid          = r_out_valid;
    assign o_slot               = r_o_slot;
    assign o_created            = r_o_created;
    assign o_evicted            = r_o_ev;
    assign o_evicted_persistent = r_o_evp;
    assign o_live_count         = r_o_live;
    assign o_high_water         = r_o_peak;

    // The live count can never pass the pool size.
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(SLOTS))
        else $error("live count exceeds pool size");

    // The high-water mark never falls below the live count.
    a_peak_ge_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_live)
        else $error("high-water mark below live count");

    // The memory is never written while the block waits for a request.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wr.en)
        else $error("memory write while idle");

    // A persistent eviction is always also an eviction.
    a_evp_implies_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evp |-> r_ev)
        else $error("persistent eviction without eviction");
endmodule
`default_nettype wire

// ===== rtl/core/psp_store.sv =====
// Slot record memory: one write port and one registered read port.
`default_nettype none
module psp_store (
    input  wire               i_clk,
    input  psp_pkg::t_wr      i_wr,
    input  psp_pkg::t_addr    i_rd_addr,
    output psp_pkg::t_rec     o_rd_data
);
    import psp_pkg::*;

    t_rec r_mem [SLOTS];
    t_rec r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the particle slot pool: directed and random requests.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import psp_pkg::*;

    // Generous run limit in cycles.
    localparam int CYCLE_LIMIT = 8_000_000;

    // One request as presented on the input channel.
    typedef struct {
        logic [1:0]  mode;
        logic [3:0]  kind;
        logic [31:0] pos [3];
        logic [31:0] vel [3];
        logic [31:0] lifetime;
        logic [31:0] frame_time;
        logic [31:0] tag;
    } t_req;

    // One expected result.
    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              created;
        logic              evicted;
        logic              evicted_p;
        logic [CNT_W-1:0]  live;
        logic [CNT_W-1:0]  high;
    } t_outcome;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_idx;
    logic [3:0] cfg_data;
    logic in_valid;
    wire  in_stall;
    logic [1:0] mode;
    logic [3:0] kind;
    logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic [31:0] lifetime, frame_time, tag;
    wire  out_valid;
    logic out_stall;
    wire  [SLOT_W-1:0] slot;
    wire  created, evicted, evicted_persistent;
    wire  [CNT_W-1:0] live_count, high_water;

    particle_slot_pool u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode), .i_kind(kind),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_vel_x(vel_x), .i_vel_y(vel_y), .i_vel_z(vel_z),
        .i_lifetime(lifetime), .i_frame_time(frame_time), .i_tag(tag),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_slot(slot), .o_created(created), .o_evicted(evicted),
        .o_evicted_persistent(evicted_persistent),
        .o_live_count(live_count), .o_high_water(high_water)
    );

    // Shadow copy of the pool, its counters and the two registers.
    bit          pool_live [SLOTS];
    logic [3:0]  pool_kind [SLOTS];
    logic [31:0] pool_pos  [SLOTS][3];
    logic [31:0] pool_vel  [SLOTS][3];
    logic [31:0] pool_age  [SLOTS];
    logic [31:0] pool_life [SLOTS];
    int          ring_ptr;
    int          live_total;
    int          peak_total;
    logic        pool_enable;
    logic [3:0]  pool_pkind;

    t_outcome pending_results[$];
    int       errors;
    int       cycles;
    bit       quiet;        // When set, neither side idles.

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiving side stalls at random except in quiet stretches.
    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 13);

    // Low 32 bits of floor(v * t / 2^16) with v signed and t unsigned.
    function automatic logic [31:0] motion_step(input logic [31:0] v, input logic [31:0] t);
        logic [63:0] prod;
        prod = {{32{v[31]}}, v} * {32'h0, t};
        return prod[47:16];
    endfunction

    function automatic int next_ring(input int i);
        return (i + 1 >= SLOTS) ? 0 : i + 1;
    endfunction

    // Applies one accepted request to the shadow pool and returns its result.
    function automatic t_outcome pool_apply(input t_req r);
        t_outcome o;
        int first, probe, target, retries;
        logic [31:0] a;
        o = '{default: '0};
        if (r.mode == MODE_CLEAR) begin
            foreach (pool_live[i]) pool_live[i] = 1'b0;
            ring_ptr = 0;
            live_total = 0;
            peak_total = 0;
        end else if (r.mode == MODE_CREATE && pool_enable) begin
            first = ring_ptr;
            probe = ring_ptr;
            retries = 0;
            forever begin
                target = probe;
                probe = next_ring(probe);
                if (!pool_live[target])
                    break;
                if (pool_kind[target] != pool_pkind) begin
                    live_total--;
                    o.evicted = 1'b1;
                    break;
                end
                retries++;
                if (retries < SLOTS / 3)
                    continue;
                // Every probe hit a persistent particle: overwrite the first one.
                target = first;
                probe = next_ring(first);
                live_total--;
                o.evicted = 1'b1;
                o.evicted_p = 1'b1;
                break;
            end
            ring_ptr = probe;
            live_total++;
            if (live_total > peak_total)
                peak_total = live_total;
            pool_live[target] = 1'b1;
            pool_kind[target] = r.kind;
            for (int k = 0; k < 3; k++) begin
                pool_pos[target][k] = r.pos[k];
                pool_vel[target][k] = r.vel[k];
            end
            pool_age[target] = '0;
            pool_life[target] = r.lifetime;
            o.slot = SLOT_W'(target);
            o.created = 1'b1;
        end else if (r.mode == MODE_TICK && pool_enable) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!pool_live[i])
                    continue;
                for (int k = 0; k < 3; k++)
                    pool_pos[i][k] += motion_step(pool_vel[i][k], r.frame_time);
                a = pool_age[i] + r.frame_time;
                if (a < pool_age[i])
                    a = '1;
                pool_age[i] = a;
                if (a > pool_life[i]) begin
                    pool_live[i] = 1'b0;
                    live_total--;
                end
            end
        end
        o.live = CNT_W'(live_total);
        o.high = CNT_W'(peak_total);
        return o;
    endfunction

    // Sends one request, with a random gap before it unless quiet.
    task automatic send_request(input t_req r);
        int gap;
        gap = (!quiet && $urandom_range(99) < 13) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        mode       <= r.mode;
        kind       <= r.kind;
        pos_x      <= r.pos[0];
        pos_y      <= r.pos[1];
        pos_z      <= r.pos[2];
        vel_x      <= r.vel[0];
        vel_y      <= r.vel[1];
        vel_z      <= r.vel[2];
        lifetime   <= r.lifetime;
        frame_time <= r.frame_time;
        tag        <= r.tag;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(pool_apply(r));
    endtask

    // Drops the request line before the pool can take it again, then drains.
    task automatic wait_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only with the pool idle.
    task automatic write_reg(input logic idx, input logic [3:0] value);
        wait_results();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ENABLE)
            pool_enable = value[0];
        else
            pool_pkind = value;
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        t_outcome e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: slot %0d live %0d", slot, live_count);
            end else begin
                e = pending_results.pop_front();
                if (slot !== e.slot || created !== e.created || evicted !== e.evicted ||
                    evicted_persistent !== e.evicted_p || live_count !== e.live ||
                    high_water !== e.high) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected slot %0d cr %0b ev %0b evp %0b",
                                  " live %0d high %0d, got slot %0d cr %0b ev %0b evp %0b",
                                  " live %0d high %0d"},
                                 e.slot, e.created, e.evicted, e.evicted_p, e.live, e.high,
                                 slot, created, evicted, evicted_persistent,
                                 live_count, high_water);
                end
            end
        end
    end

    function automatic t_req random_create(input logic [3:0] k);
        t_req r;
        r.mode = MODE_CREATE;
        r.kind = k;
        for (int i = 0; i < 3; i++) begin
            r.pos[i] = $urandom;
            r.vel[i] = $urandom;
        end
        r.lifetime = ($urandom_range(99) < 70) ? $urandom_range(0, 32'h60000) : $urandom;
        r.frame_time = $urandom;
        r.tag = $urandom;
        return r;
    endfunction

    function automatic t_req random_tick();
        t_req r;
        int pick;
        r = random_create(4'($urandom));
        r.mode = MODE_TICK;
        pick = $urandom_range(99);
        r.frame_time = (pick < 70) ? $urandom_range(0, 32'h20000) :
                       (pick < 90) ? $urandom : 32'h0;
        return r;
    endfunction

    // Field extremes, every mode, the disabled case and a clear while disabled.
    task automatic test_directed;
        t_req r;
        r = random_create(4'd0);
        r.pos = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
        r.vel = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        r.lifetime = 32'hFFFF_FFFF;
        r.tag = 32'hFFFF_FFFF;
        send_request(r);
        r = random_create(4'd15);
        r.lifetime = 32'h0;
        r.tag = 32'h0;
        send_request(r);
        r = random_create(4'd2);
        r.lifetime = 32'h0001_0000;
        send_request(r);
        r = random_tick();
        r.frame_time = 32'h0;
        send_request(r);
        r.frame_time = 32'h0000_8000;
        send_request(r);
        r.frame_time = 32'hFFFF_FFFF;
        send_request(r);
        r.frame_time = 32'hFFFF_FFFF;
        send_request(r);
        r.mode = 2'd3;      // unused mode
        send_request(r);
        send_request(random_create(4'd7));
        write_reg(CFG_ENABLE, 4'd0);
        send_request(random_create(4'd3));
        send_request(random_tick());
        r.mode = MODE_CLEAR;
        send_request(r);
        send_request(random_create(4'd3));
        write_reg(CFG_ENABLE, 4'd1);
        send_request(random_create(4'd3));
        r.mode = MODE_CLEAR;
        send_request(r);
        wait_results();
    endtask

    // Fill the pool with persistent particles so later creates must force an eviction.
    task automatic test_forced_eviction;
        t_req r;
        write_reg(CFG_PKIND, 4'd15);
        for (int i = 0; i < SLOTS; i++)
            send_request(random_create(4'd15));
        for (int i = 0; i < 4; i++)
            send_request(random_create(4'($urandom)));
        // Persistent particles now lose their protection.
        write_reg(CFG_PKIND, 4'd0);
        for (int i = 0; i < 4; i++)
            send_request(random_create(4'd0));
        send_request(random_tick());
        r = random_tick();
        r.frame_time = 32'hFFFF_FFFF;
        send_request(r);
        r.mode = MODE_CLEAR;
        send_request(r);
        wait_results();
    endtask

    // Mostly creates with occasional ticks, clears and the unused mode.
    task automatic test_random(input int count, input logic [3:0] pkind);
        t_req r;
        int pick;
        write_reg(CFG_PKIND, pkind);
        for (int n = 0; n < count; n++) begin
            quiet = (n >= count / 3 && n < count / 2);
            pick = $urandom_range(999);
            if (pick < 880)
                r = random_create(($urandom_range(3) == 0) ? pkind : 4'($urandom));
            else if (pick < 950)
                r = random_tick();
            else begin
                r = random_tick();
                r.mode = (pick < 975) ? MODE_CLEAR : 2'd3;
            end
            send_request(r);
        end
        quiet = 1'b0;
        wait_results();
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = '0;
        kind = '0;
        {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z} = '0;
        {lifetime, frame_time, tag} = '0;
        out_stall = 1'b0;
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        foreach (pool_live[i]) pool_live[i] = 1'b0;
        ring_ptr = 0;
        live_total = 0;
        peak_total = 0;
        pool_enable = 1'b1;
        pool_pkind = 4'd2;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_forced_eviction();
        test_random(600, 4'd2);
        test_random(600, 4'd9);

        repeat (50) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
